// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file cps_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge of clk unless rst is high
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");

// check that cond never holds while rst is low
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ----- hw/rtl/cps_pkg.sv -----
// Shared constants, codes, types and functions of the column predicate scan.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package cps_pkg;

   localparam int WORD_BITS   = 64;
   localparam int CODE_BITS   = 32;
   localparam int RESULT_BITS = 64;
   localparam int FIELD_BITS  = 32;
   localparam int FILL_BITS   = $clog2(WORD_BITS);
   localparam int WIDTH_BITS  = 6;
   localparam int CSR_BITS    = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_BITS-1:0] CSR_COMPARE_OP      = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_COMBINE_OP      = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_COMPARE_LITERAL = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_CODE_WIDTH      = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_COLUMN_MODE     = 3'd4;

   localparam logic [2:0] CMP_LT = 3'd0;
   localparam logic [2:0] CMP_GT = 3'd1;
   localparam logic [2:0] CMP_LE = 3'd2;
   localparam logic [2:0] CMP_GE = 3'd3;
   localparam logic [2:0] CMP_EQ = 3'd4;
   localparam logic [2:0] CMP_NE = 3'd5;

   localparam logic [1:0] COMB_SET = 2'd0;
   localparam logic [1:0] COMB_AND = 2'd1;
   localparam logic [1:0] COMB_OR  = 2'd2;

   typedef struct packed {
      logic hit;
      logic last;
   } item_type;

   function automatic logic [CODE_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
      width_mask = ~({CODE_BITS{1'b1}} << w);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cps_front.sv -----
// Front end: configuration registers, tuple acceptance and predicate evaluation.
// Depends on cps_pkg; feeds one classified bit per tuple into the queue.
`default_nettype none

module cps_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic [cps_pkg::CSR_BITS-1:0]       csr_index,
   input  wire logic [cps_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                               req_valid,
   input  wire logic [cps_pkg::FIELD_BITS-1:0]     req_tuple_code,
   input  wire logic [cps_pkg::FIELD_BITS-1:0]     req_other_code,
   input  wire logic                               req_prior_bit,
   input  wire logic                               req_last_tuple,
   input  wire logic                               q_full,
   output logic                                    push,
   output cps_pkg::item_type                       push_item
);

   logic [2:0]                          compare_op_ff, compare_op_in;
   logic [1:0]                          combine_op_ff, combine_op_in;
   logic [cps_pkg::CODE_BITS-1:0]       literal_ff, literal_in;
   logic [cps_pkg::WIDTH_BITS-1:0]      code_width_ff, code_width_in;
   logic                                column_mode_ff, column_mode_in;
   logic [cps_pkg::CODE_BITS-1:0]       mask;
   logic [cps_pkg::CODE_BITS-1:0]       a_val;
   logic [cps_pkg::CODE_BITS-1:0]       b_val;
   logic                                cmp_bit;
   logic                                hit;

   always_comb begin
      compare_op_in  = compare_op_ff;
      combine_op_in  = combine_op_ff;
      literal_in     = literal_ff;
      code_width_in  = code_width_ff;
      column_mode_in = column_mode_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cps_pkg::CSR_COMPARE_OP:      compare_op_in  = csr_wdata[2:0];
            cps_pkg::CSR_COMBINE_OP:      combine_op_in  = csr_wdata[1:0];
            cps_pkg::CSR_COMPARE_LITERAL: literal_in     = csr_wdata[cps_pkg::CODE_BITS-1:0];
            cps_pkg::CSR_CODE_WIDTH:      code_width_in  = csr_wdata[cps_pkg::WIDTH_BITS-1:0];
            cps_pkg::CSR_COLUMN_MODE:     column_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_op_ff  <= cps_pkg::CMP_LT;
         combine_op_ff  <= cps_pkg::COMB_SET;
         literal_ff     <= '0;
         code_width_ff  <= cps_pkg::WIDTH_BITS'(cps_pkg::CODE_BITS);
         column_mode_ff <= 1'b0;
      end else begin
         compare_op_ff  <= compare_op_in;
         combine_op_ff  <= combine_op_in;
         literal_ff     <= literal_in;
         code_width_ff  <= code_width_in;
         column_mode_ff <= column_mode_in;
      end
   end

   always_comb begin
      mask  = cps_pkg::width_mask(code_width_ff);
      a_val = req_tuple_code[cps_pkg::CODE_BITS-1:0] & mask;
      b_val = column_mode_ff ? (req_other_code[cps_pkg::CODE_BITS-1:0] & mask)
                             : (literal_ff & mask);
      unique case (compare_op_ff)
         cps_pkg::CMP_LT: cmp_bit = (a_val <  b_val);
         cps_pkg::CMP_GT: cmp_bit = (a_val >  b_val);
         cps_pkg::CMP_LE: cmp_bit = (a_val <= b_val);
         cps_pkg::CMP_GE: cmp_bit = (a_val >= b_val);
         cps_pkg::CMP_EQ: cmp_bit = (a_val == b_val);
         cps_pkg::CMP_NE: cmp_bit = (a_val != b_val);
         default:         cmp_bit = 1'b0;
      endcase
      unique case (combine_op_ff)
         cps_pkg::COMB_AND: hit = cmp_bit & req_prior_bit;
         cps_pkg::COMB_OR:  hit = cmp_bit | req_prior_bit;
         default:           hit = cmp_bit;
      endcase
   end

   assign push           = req_valid && !q_full;
   assign push_item.hit  = hit;
   assign push_item.last = req_last_tuple;

endmodule

`default_nettype wire

// ----- hw/rtl/cps_queue.sv -----
// Short queue of classified tuple bits between front and back end.
// Depends on cps_pkg for the item type and depth.
`default_nettype none

module cps_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  cps_pkg::item_type         push_item,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      head_valid,
   output cps_pkg::item_type         head_item
);

   cps_pkg::item_type                  slot_ff [cps_pkg::QUEUE_DEPTH];
   logic [cps_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cps_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cps_pkg::QCNT_BITS-1:0]      count_ff, count_in;

   assign full       = (count_ff == cps_pkg::QCNT_BITS'(cps_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + cps_pkg::QCNT_BITS'(push) - cps_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/cps_back.sv -----
// Back end: packs filter bits into words and holds the result register.
// Depends on cps_pkg; drains the queue one tuple per cycle unless a completed word is held by rsp_stall.
`default_nettype none

module cps_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  cps_pkg::item_type                      head_item,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [cps_pkg::RESULT_BITS-1:0]        rsp_result_word,
   output logic                                   rsp_last_word
);

   logic [cps_pkg::WORD_BITS-1:0]  pack_ff, pack_in;
   logic [cps_pkg::FILL_BITS-1:0]  fill_ff, fill_in;
   logic [cps_pkg::WORD_BITS-1:0]  word_ff, word_in;
   logic                           last_ff, last_in;
   logic                           valid_ff, valid_in;
   logic [cps_pkg::WORD_BITS-1:0]  merged;
   logic                           emit;
   logic                           out_free;

   always_comb begin
      merged   = pack_ff | (cps_pkg::WORD_BITS'(head_item.hit) << fill_ff);
      emit     = head_item.last ||
                 (fill_ff == cps_pkg::FILL_BITS'(cps_pkg::WORD_BITS - 1));
      out_free = !valid_ff || !rsp_stall;
      pop      = head_valid && (!emit || out_free);

      pack_in  = pack_ff;
      fill_in  = fill_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      valid_in = out_free ? 1'b0 : valid_ff;
      if (pop) begin
         if (emit) begin
            word_in  = merged;
            last_in  = head_item.last;
            valid_in = 1'b1;
            pack_in  = '0;
            fill_in  = '0;
         end else begin
            pack_in  = merged;
            fill_in  = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff  <= '0;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pack_ff  <= pack_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_word = cps_pkg::RESULT_BITS'(word_ff);
   assign rsp_last_word   = last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/column_predicate_scan_top.sv -----
// Top level of the column predicate scan: front end, queue and back end.
// Depends on cps_pkg, cps_front, cps_queue and cps_back.
//
// Accepts one tuple per clock and evaluates its predicate in the cycle it is
// accepted; the filter bit goes through a four-entry queue to the packer, and
// a result word is registered as the tuple that fills it (64th bit or
// last_tuple) leaves the queue. Sustained rate is one tuple per cycle, set
// by the front end's combinational compare and the one-pop-per-cycle packer;
// a stalled result register backs up the queue, and req_stall rises once its
// four entries are full. Configuration writes are taken every cycle (csr_ready
// is tied high) and must only be issued while no tuple is in flight.
`default_nettype none

module column_predicate_scan_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cps_pkg::CSR_BITS-1:0]       csr_index,
   input  wire logic [cps_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [cps_pkg::FIELD_BITS-1:0]     req_tuple_code,
   input  wire logic [cps_pkg::FIELD_BITS-1:0]     req_other_code,
   input  wire logic                               req_prior_bit,
   input  wire logic                               req_last_tuple,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [cps_pkg::RESULT_BITS-1:0]         rsp_result_word,
   output logic                                    rsp_last_word
);

   logic               q_full;
   logic               push;
   cps_pkg::item_type  push_item;
   logic               pop;
   logic               head_valid;
   cps_pkg::item_type  head_item;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   cps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_tuple_code (req_tuple_code),
      .req_other_code (req_other_code),
      .req_prior_bit  (req_prior_bit),
      .req_last_tuple (req_last_tuple),
      .q_full         (q_full),
      .push           (push),
      .push_item      (push_item)
   );

   cps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   cps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/cps_checker.sv -----
// Port-level checker for column_predicate_scan_top, attached by bind.
// Depends on cps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cps_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [cps_pkg::RESULT_BITS-1:0]   rsp_result_word,
   input  wire logic                              rsp_last_word
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_word) && $stable(rsp_last_word))
   `ASSERT_CLK(a_rsp_clear_after_reset, clock, 1'b0, reset |=> !rsp_valid)
   `ASSERT_CLK(a_req_open_after_reset, clock, 1'b0, reset |=> !req_stall)
   `ASSERT_NEVER(a_stall_without_backlog, clock, reset, $rose(req_stall) && !$past(req_valid))

endmodule

bind column_predicate_scan_top cps_checker u_cps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_word (rsp_result_word),
   .rsp_last_word   (rsp_last_word)
);

`default_nettype wire

// ----- tb/column_predicate_scan_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for column_predicate_scan_top: a directed stimulus list, then
// random register phases with bursty tuples and result stalls, checked against a local
// predictor and listed words. Depends on cps_pkg and the column_predicate_scan_top RTL.
module column_predicate_scan_top_tb;

   localparam logic [2:0] CMP_NONE_6  = 3'd6;
   localparam logic [2:0] CMP_NONE_7  = 3'd7;
   localparam logic [1:0] COMB_NONE_3 = 2'd3;
   localparam logic [cps_pkg::CSR_BITS-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [cps_pkg::CSR_BITS-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam int QUIET_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int NUM_PHASES      = 9;
   localparam int PHASE_TUPLES    = 100;
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      logic [cps_pkg::RESULT_BITS-1:0] word;
      logic                            last;
   } filter_word_type;

   typedef struct {
      bit                                is_csr;
      logic [cps_pkg::CSR_BITS-1:0]      idx;
      logic [cps_pkg::CSR_DATA_BITS-1:0] data;
      logic [cps_pkg::FIELD_BITS-1:0]    code;
      logic [cps_pkg::FIELD_BITS-1:0]    other;
      logic                              prior;
      logic                              last;
      bit                                typed;
      logic [cps_pkg::RESULT_BITS-1:0]   word;
   } stim_row_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [cps_pkg::CSR_BITS-1:0]      csr_index;
   logic [cps_pkg::CSR_DATA_BITS-1:0] csr_wdata;
   logic                              req_valid;
   logic                              req_stall;
   logic [cps_pkg::FIELD_BITS-1:0]    req_tuple_code;
   logic [cps_pkg::FIELD_BITS-1:0]    req_other_code;
   logic                              req_prior_bit;
   logic                              req_last_tuple;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [cps_pkg::RESULT_BITS-1:0]   rsp_result_word;
   logic                              rsp_last_word;

   logic [2:0]                        cfg_compare_op;
   logic [1:0]                        cfg_combine_op;
   logic [cps_pkg::CODE_BITS-1:0]     cfg_literal;
   logic [cps_pkg::WIDTH_BITS-1:0]    cfg_code_width;
   logic                              cfg_column_mode;
   logic [cps_pkg::RESULT_BITS-1:0]   pack_word;
   int                                pack_fill;

   filter_word_type pending_words[$];
   stim_row_type    stim_rows[$];
   filter_word_type want;

   int mismatches;
   int tuples_sent;
   int words_checked;
   int csr_writes;
   int input_stall_cycles;
   int quiet_cycles;
   bit hold_off_req;
   int hold_left;
   int stall_mode;
   int mode_left;

   column_predicate_scan_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tuple_code  (req_tuple_code),
      .req_other_code  (req_other_code),
      .req_prior_bit   (req_prior_bit),
      .req_last_tuple  (req_last_tuple),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [cps_pkg::CODE_BITS-1:0] active_mask();
      if (cfg_code_width >= cps_pkg::CODE_BITS) return '1;
      return (32'd1 << cfg_code_width) - 32'd1;
   endfunction

   task automatic scan_tuple(input logic [cps_pkg::FIELD_BITS-1:0] code, other,
                             input logic prior, last,
                             output bit emit, output filter_word_type res);
      logic [cps_pkg::CODE_BITS-1:0] a;
      logic [cps_pkg::CODE_BITS-1:0] b;
      logic                          hit;
      a = code & active_mask();
      b = cfg_column_mode ? (other & active_mask()) : (cfg_literal & active_mask());
      case (cfg_compare_op)
         cps_pkg::CMP_LT: hit = a < b;
         cps_pkg::CMP_GT: hit = a > b;
         cps_pkg::CMP_LE: hit = a <= b;
         cps_pkg::CMP_GE: hit = a >= b;
         cps_pkg::CMP_EQ: hit = a == b;
         cps_pkg::CMP_NE: hit = a != b;
         default:         hit = 1'b0;
      endcase
      if (cfg_combine_op == cps_pkg::COMB_AND) hit = hit & prior;
      else if (cfg_combine_op == cps_pkg::COMB_OR) hit = hit | prior;
      pack_word[pack_fill] = hit;
      pack_fill++;
      emit = (pack_fill >= cps_pkg::WORD_BITS) || last;
      res.word = pack_word;
      res.last = last;
      if (emit) begin
         pack_word = '0;
         pack_fill = 0;
      end
   endtask

   // keep data near the compare value so that every outcome shows up
   function automatic logic [cps_pkg::FIELD_BITS-1:0] near_code(
      input logic [cps_pkg::FIELD_BITS-1:0] base);
      case ($urandom_range(0, 4))
         0:       return $urandom();
         1:       return base;
         2:       return base + $urandom_range(0, 2) - 1;
         3:       return base ^ ($urandom() & ~active_mask());
         default: return base ^ (32'd1 << $urandom_range(0, 31));
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input logic [63:0] want_v, got_v);
      if (mismatches < MAX_REPORTS)
         $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
      mismatches++;
   endfunction

   task automatic add_csr(input logic [cps_pkg::CSR_BITS-1:0] idx,
                          input logic [cps_pkg::CSR_DATA_BITS-1:0] data);
      stim_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.idx = idx;
      r.data = data;
      stim_rows.push_back(r);
   endtask

   task automatic add_tuple(input logic [cps_pkg::FIELD_BITS-1:0] code, other,
                            input logic prior, last);
      stim_row_type r;
      r = '{default: '0};
      r.code = code;
      r.other = other;
      r.prior = prior;
      r.last = last;
      stim_rows.push_back(r);
   endtask

   task automatic add_checked(input logic [cps_pkg::FIELD_BITS-1:0] code, other,
                              input logic prior,
                              input logic [cps_pkg::RESULT_BITS-1:0] word);
      stim_row_type r;
      r = '{default: '0};
      r.code = code;
      r.other = other;
      r.prior = prior;
      r.last = 1'b1;
      r.typed = 1'b1;
      r.word = word;
      stim_rows.push_back(r);
   endtask

   task automatic send_tuple(input logic [cps_pkg::FIELD_BITS-1:0] code, other,
                             input logic prior, last,
                             input bit typed, input logic [cps_pkg::RESULT_BITS-1:0] typed_word);
      bit              emit;
      filter_word_type res;
      req_valid <= 1'b1;
      req_tuple_code <= code;
      req_other_code <= other;
      req_prior_bit <= prior;
      req_last_tuple <= last;
      do @(posedge clock); while (req_stall);
      scan_tuple(code, other, prior, last, emit, res);
      tuples_sent++;
      if (emit) begin
         if (typed) res.word = typed_word;
         pending_words.push_back(res);
      end
   endtask

   task automatic write_csr(input logic [cps_pkg::CSR_BITS-1:0] idx,
                            input logic [cps_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         cps_pkg::CSR_COMPARE_OP:      cfg_compare_op = data[2:0];
         cps_pkg::CSR_COMBINE_OP:      cfg_combine_op = data[1:0];
         cps_pkg::CSR_COMPARE_LITERAL: cfg_literal = data;
         cps_pkg::CSR_CODE_WIDTH:      cfg_code_width = data[cps_pkg::WIDTH_BITS-1:0];
         cps_pkg::CSR_COLUMN_MODE:     cfg_column_mode = data[0];
         default: ;
      endcase
   endtask

   // drop valid, drain pending words, then let in-flight tuples settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected result_word", '0, rsp_result_word);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_result_word !== want.word)
               report_mismatch("result_word", want.word, rsp_result_word);
            if (rsp_last_word !== want.last)
               report_mismatch("last_word", 64'(want.last), 64'(rsp_last_word));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   initial begin
      int                             p;
      int                             k;
      int                             sent;
      int                             blk_len;
      int                             burst_left;
      int                             gap;
      bit                             no_gaps;
      logic [cps_pkg::FIELD_BITS-1:0] code;
      logic [cps_pkg::FIELD_BITS-1:0] other;
      logic [cps_pkg::CODE_BITS-1:0]  lit;
      logic                           last;
      logic [cps_pkg::WIDTH_BITS-1:0] width;
      logic [2:0]                     op_cycle[8];
      logic [1:0]                     comb_cycle[4];

      op_cycle = '{cps_pkg::CMP_LT, cps_pkg::CMP_GT, cps_pkg::CMP_LE, cps_pkg::CMP_GE,
                   cps_pkg::CMP_EQ, cps_pkg::CMP_NE, CMP_NONE_6, CMP_NONE_7};
      comb_cycle = '{cps_pkg::COMB_SET, cps_pkg::COMB_AND, cps_pkg::COMB_OR, COMB_NONE_3};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_tuple_code = '0;
      req_other_code = '0;
      req_prior_bit = 1'b0;
      req_last_tuple = 1'b0;
      cfg_compare_op = cps_pkg::CMP_LT;
      cfg_combine_op = cps_pkg::COMB_SET;
      cfg_literal = '0;
      cfg_code_width = cps_pkg::WIDTH_BITS'(cps_pkg::CODE_BITS);
      cfg_column_mode = 1'b0;
      pack_word = '0;
      pack_fill = 0;
      hold_off_req = 1'b0;

      // registers at reset values: less-than against a zero literal never hits
      add_checked(32'h0000_0000, 32'h0, 1'b0, 64'h0);
      add_checked(32'hFFFF_FFFF, 32'h0, 1'b1, 64'h0);
      add_csr(cps_pkg::CSR_COMPARE_OP, cps_pkg::CMP_EQ);
      add_csr(cps_pkg::CSR_COMPARE_LITERAL, 32'hFFFF_FFFF);
      add_checked(32'hFFFF_FFFF, 32'h0, 1'b0, 64'h1);
      add_checked(32'h0000_0000, 32'h0, 1'b1, 64'h0);
      // empty mask: every code equals the literal
      add_csr(cps_pkg::CSR_CODE_WIDTH, 32'd0);
      add_checked(32'h1234_5678, 32'h0, 1'b0, 64'h1);
      // width above the code size saturates
      add_csr(cps_pkg::CSR_CODE_WIDTH, 32'd63);
      add_checked(32'hFFFF_FFFF, 32'h0, 1'b0, 64'h1);
      add_checked(32'h7FFF_FFFF, 32'h0, 1'b0, 64'h0);
      add_csr(cps_pkg::CSR_CODE_WIDTH, 32'd1);
      add_checked(32'hFFFF_FFFE, 32'h0, 1'b0, 64'h0);
      add_checked(32'h0000_0001, 32'h0, 1'b0, 64'h1);
      // unused compare codes never hit, unused combine code acts as set
      add_csr(cps_pkg::CSR_COMPARE_OP, CMP_NONE_6);
      add_checked(32'h0000_0001, 32'h0, 1'b1, 64'h0);
      add_csr(cps_pkg::CSR_COMPARE_OP, CMP_NONE_7);
      add_csr(cps_pkg::CSR_COMBINE_OP, cps_pkg::COMB_OR);
      add_checked(32'h0000_0001, 32'h0, 1'b1, 64'h1);
      add_checked(32'h0000_0001, 32'h0, 1'b0, 64'h0);
      add_csr(cps_pkg::CSR_COMBINE_OP, COMB_NONE_3);
      add_checked(32'h0000_0001, 32'h0, 1'b1, 64'h0);
      add_csr(cps_pkg::CSR_COMPARE_OP, cps_pkg::CMP_NE);
      add_csr(cps_pkg::CSR_COMBINE_OP, cps_pkg::COMB_AND);
      add_csr(cps_pkg::CSR_COLUMN_MODE, 32'd1);
      add_csr(cps_pkg::CSR_CODE_WIDTH, 32'd32);
      // writes past the register list must not disturb anything
      add_csr(CSR_SPARE_FIRST, 32'hFFFF_FFFF);
      add_csr(CSR_SPARE_LAST, 32'hFFFF_FFFF);
      add_checked(32'h0000_0001, 32'h0000_0002, 1'b1, 64'h1);
      add_checked(32'h0000_0001, 32'h0000_0002, 1'b0, 64'h0);
      add_checked(32'h0000_0007, 32'h0000_0007, 1'b1, 64'h0);
      add_csr(cps_pkg::CSR_COMBINE_OP, cps_pkg::COMB_SET);
      add_csr(cps_pkg::CSR_COMPARE_OP, cps_pkg::CMP_LT);
      add_tuple(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_tuple(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0);
      add_csr(cps_pkg::CSR_COMPARE_OP, cps_pkg::CMP_GT);
      add_tuple(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b0);
      add_tuple(32'h0000_0005, 32'h0000_0005, 1'b1, 1'b0);
      add_csr(cps_pkg::CSR_COMPARE_OP, cps_pkg::CMP_LE);
      add_tuple(32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0);
      add_tuple(32'h0000_0006, 32'h0000_0005, 1'b1, 1'b0);
      add_csr(cps_pkg::CSR_COMPARE_OP, cps_pkg::CMP_GE);
      add_csr(cps_pkg::CSR_COLUMN_MODE, 32'd0);
      add_csr(cps_pkg::CSR_COMPARE_LITERAL, 32'h8000_0000);
      add_tuple(32'h8000_0000, 32'h0, 1'b0, 1'b0);
      add_tuple(32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_csr) begin
            if (i == 0 || !stim_rows[i-1].is_csr) wait_idle();
            write_csr(stim_rows[i].idx, stim_rows[i].data);
            if (i == stim_rows.size() - 1 || !stim_rows[i+1].is_csr) csr_valid <= 1'b0;
         end else begin
            send_tuple(stim_rows[i].code, stim_rows[i].other, stim_rows[i].prior,
                       stim_rows[i].last, stim_rows[i].typed, stim_rows[i].word);
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         case (p)
            0:       width = cps_pkg::WIDTH_BITS'(cps_pkg::CODE_BITS);
            1:       width = cps_pkg::WIDTH_BITS'(1);
            2:       width = cps_pkg::WIDTH_BITS'(0);
            3:       width = cps_pkg::WIDTH_BITS'($urandom_range(cps_pkg::CODE_BITS + 1, 63));
            default: width = cps_pkg::WIDTH_BITS'($urandom_range(1, cps_pkg::CODE_BITS));
         endcase
         case ($urandom_range(0, 3))
            0:       lit = '0;
            1:       lit = '1;
            default: lit = $urandom();
         endcase
         write_csr(cps_pkg::CSR_COMPARE_OP, ($urandom() << 3) | 32'(op_cycle[p % 8]));
         write_csr(cps_pkg::CSR_COMBINE_OP,
                   ($urandom() << 2) | 32'(comb_cycle[$urandom_range(0, 3)]));
         write_csr(cps_pkg::CSR_COMPARE_LITERAL, lit);
         write_csr(cps_pkg::CSR_CODE_WIDTH, ($urandom() << cps_pkg::WIDTH_BITS) | 32'(width));
         write_csr(cps_pkg::CSR_COLUMN_MODE, ($urandom() << 1) | 32'($urandom_range(0, 1)));
         if ($urandom_range(0, 1))
            write_csr(cps_pkg::CSR_BITS'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                      $urandom());
         csr_valid <= 1'b0;
         if (p == NUM_PHASES / 2) hold_off_req = 1'b1;

         no_gaps = ($urandom_range(0, 3) == 0);
         burst_left = $urandom_range(1, 24);
         sent = 0;
         while (sent < PHASE_TUPLES) begin
            case ($urandom_range(0, 7))
               0:       blk_len = 1;
               1:       blk_len = $urandom_range(2, 5);
               2:       blk_len = cps_pkg::WORD_BITS;
               3:       blk_len = $urandom_range(cps_pkg::WORD_BITS - 1, cps_pkg::WORD_BITS + 1);
               4:       blk_len = 2 * cps_pkg::WORD_BITS;
               default: blk_len = $urandom_range(1, 100);
            endcase
            for (k = 0; k < blk_len && sent < PHASE_TUPLES; k++) begin
               if (cfg_column_mode) begin
                  other = near_code($urandom());
                  code = near_code(other);
               end else begin
                  code = near_code(cfg_literal);
                  other = $urandom();
               end
               last = (k == blk_len - 1) ? ($urandom_range(0, 9) != 0)
                                         : ($urandom_range(0, 149) == 0);
               send_tuple(code, other, 1'($urandom_range(0, 1)), last, 1'b0, '0);
               sent++;
               burst_left--;
               if (burst_left <= 0) begin
                  gap = no_gaps ? 0 : $urandom_range(1, 6);
                  if (gap > 0) begin
                     req_valid <= 1'b0;
                     repeat (gap) @(posedge clock);
                  end
                  burst_left = $urandom_range(1, 24);
               end
            end
         end
      end

      wait_idle();
      $display("Scanned %0d tuples into %0d checked words across %0d register writes.",
               tuples_sent, words_checked, csr_writes);
      $display("Tuple input was back-pressured for %0d cycles.", input_stall_cycles);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/cps_pkg.sv
hw/rtl/cps_front.sv
hw/rtl/cps_queue.sv
hw/rtl/cps_back.sv
hw/rtl/column_predicate_scan_top.sv
hw/rtl/cps_checker.sv
tb/column_predicate_scan_top_tb.sv
